// ===== design/utf8d_pkg.sv =====
// Package of the UTF-8 stream decoder: result and push types, byte
// classification constants and the lead-byte payload function.
// Used by utf8d_decode, utf8d_result_fifo and utf8_stream_decoder; depends on nothing.
`default_nettype none

package utf8d_pkg;

	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_TAG     = 8'h80;
	localparam logic [7:0] CONT_PAYLOAD = 8'h3F;
	localparam logic [7:0] SEQ_LEN_MAX  = 8'hFF;
	localparam logic [7:0] SEQ_LEN_ONE  = 8'h01;

	// Default depth of the result queue; must be at least 2.
	localparam int unsigned RES_FIFO_DEPTH = 4;

	typedef struct packed {
		logic [31:0] codepoint;
		logic [7:0]  seq_length;
		logic        last_of_run;
	} result_t;

	// Results produced by one byte, packed from slot 0 upward.
	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} push_t;

	// Payload bits of a lead byte: the bits below its first zero. Seven or
	// eight leading ones leave no payload.
	function automatic logic [31:0] lead_payload(input logic [7:0] b);
		logic [7:0] m;
		begin
			priority casez (b)
				8'b0???????: m = 8'h7F;
				8'b10??????: m = 8'h3F;
				8'b110?????: m = 8'h1F;
				8'b1110????: m = 8'h0F;
				8'b11110???: m = 8'h07;
				8'b111110??: m = 8'h03;
				8'b1111110?: m = 8'h01;
				default:     m = 8'h00;
			endcase
			lead_payload = {24'h000000, b & m};
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/utf8d_if.sv =====
// Handshake channels of the UTF-8 stream decoder: the byte channel and the
// codepoint result channel. Depends on nothing.
`default_nettype none

interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface utf8d_cp_if;
	logic        valid;
	logic        ready;
	logic [31:0] codepoint;
	logic [7:0]  seq_length;
	logic        last_of_run;

	modport source(output valid, output codepoint, output seq_length, output last_of_run,
		input ready);
	modport sink(input valid, input codepoint, input seq_length, input last_of_run,
		output ready);
endinterface

`default_nettype wire

// ===== design/utf8d_decode.sv =====
// Input register and single-pass decode of one byte against the open sequence.
// Depends on utf8d_pkg and utf8d_byte_if.
`default_nettype none

module utf8d_decode (
	input  logic              clk,
	input  logic              arst_n,
	utf8d_byte_if.sink        bytes,
	input  logic              room,
	output utf8d_pkg::push_t  push
);
	import utf8d_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        seq_open_q;
	logic [31:0] accum_q;
	logic [7:0]  byte_count_q;
	logic        seq_open_n;
	logic [31:0] accum_n;
	logic [7:0]  byte_count_n;
	logic        is_cont;
	logic        is_ascii;
	result_t     closed_r;
	result_t     ascii_r;
	push_t       push_c;

	// The registered byte moves on only when the queue can take two results.
	assign adv         = valid_s1 && room;
	assign bytes.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	assign is_cont  = (byte_s1 & CONT_MASK) == CONT_TAG;
	assign is_ascii = !byte_s1[7];

	always_comb begin
		closed_r.codepoint   = accum_q;
		closed_r.seq_length  = byte_count_q;
		closed_r.last_of_run = !is_ascii;
		ascii_r.codepoint    = {24'h000000, byte_s1};
		ascii_r.seq_length   = SEQ_LEN_ONE;
		ascii_r.last_of_run  = 1'b1;

		push_c       = '0;
		seq_open_n   = seq_open_q;
		accum_n      = accum_q;
		byte_count_n = byte_count_q;

		if (seq_open_q && is_cont) begin
			accum_n = {accum_q[25:0], byte_s1[5:0] & CONT_PAYLOAD[5:0]};
			if (byte_count_q != SEQ_LEN_MAX) begin
				byte_count_n = byte_count_q + 8'd1;
			end
		end else begin
			// A closing byte emits the pending sequence first, then is handled
			// as if no sequence were open.
			if (seq_open_q) begin
				push_c.res0 = closed_r;
				push_c.n    = 2'd1;
				if (is_ascii) begin
					push_c.res1 = ascii_r;
					push_c.n    = 2'd2;
				end
			end else if (is_ascii) begin
				push_c.res0 = ascii_r;
				push_c.n    = 2'd1;
			end
			if (is_ascii) begin
				seq_open_n = 1'b0;
			end else begin
				seq_open_n   = 1'b1;
				accum_n      = lead_payload(byte_s1);
				byte_count_n = SEQ_LEN_ONE;
			end
		end

		push = push_c;
		if (!adv) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_open_q   <= 1'b0;
			accum_q      <= '0;
			byte_count_q <= '0;
		end else if (adv) begin
			seq_open_q   <= seq_open_n;
			accum_q      <= accum_n;
			byte_count_q <= byte_count_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/utf8d_result_fifo.sv =====
// Result queue of the UTF-8 stream decoder: takes up to two results a cycle,
// hands out one while codes is ready. Depends on utf8d_pkg and utf8d_cp_if.
`default_nettype none

module utf8d_result_fifo #(
	parameter int unsigned Depth = utf8d_pkg::RES_FIFO_DEPTH,
	localparam int unsigned LevelW = $clog2(Depth + 1),
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8d_pkg::push_t  push,
	utf8d_cp_if.source        codes,
	output logic              room,
	output logic [LevelW-1:0] level
);
	import utf8d_pkg::*;

	result_t           mem_q [Depth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [LevelW-1:0] level_q;
	logic [PtrW-1:0]   wr1;
	logic [PtrW-1:0]   wr2;
	logic [PtrW-1:0]   rd1;
	logic              pop;

	assign wr1 = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
	assign wr2 = (wr1 == PtrW'(Depth - 1)) ? '0 : wr1 + PtrW'(1);
	assign rd1 = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);

	assign codes.valid       = level_q != '0;
	assign codes.codepoint   = mem_q[rd_q].codepoint;
	assign codes.seq_length  = mem_q[rd_q].seq_length;
	assign codes.last_of_run = mem_q[rd_q].last_of_run;
	assign pop               = codes.valid && codes.ready;

	assign room  = level_q <= LevelW'(Depth - 2);
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			unique case (push.n)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd1;
			end
			level_q <= level_q + LevelW'(push.n) - LevelW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== design/utf8_stream_decoder.sv =====
// UTF-8 stream decoder, top level: byte input register and decode, result queue.
// Depends on utf8d_pkg, utf8d_if, utf8d_decode and utf8d_result_fifo.
//
// Usage: raw bytes of UTF-8 text enter on the bytes channel, one item per byte.
// Decoded codepoints leave on the codes channel with their byte length and a
// flag marking the last result caused by a byte. Decoding is greedy and does
// no validation; a sequence stays pending until a non-continuation byte ends it,
// so a byte can yield zero, one or two results.
// Path: an accepted byte is held in the single input register, decoded
// combinationally, and its results are written into the queue that feeds codes.
// Throughput: one byte per cycle while the queue has room for two results;
// the queue drains one result per cycle while codes is ready.
// Stalls: a byte leaves the input register only when the result queue has room
// for two results, so when codes is held off the queue fills and bytes.ready
// drops; no result is lost.
// Reset: arst_n clears the open sequence, the input register and the queue.
`default_nettype none

module utf8_stream_decoder #(
	parameter int unsigned FifoDepth = utf8d_pkg::RES_FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	utf8d_byte_if.sink    bytes,
	utf8d_cp_if.source    codes
);
	import utf8d_pkg::*;

	localparam int unsigned LevelW = $clog2(FifoDepth + 1);

	push_t             push;
	logic              room;
	logic [LevelW-1:0] level;

	utf8d_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.room   (room),
		.push   (push)
	);

	utf8d_result_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.codes  (codes),
		.room   (room),
		.level  (level)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LevelW'(FifoDepth))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("results pushed without room for two");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.res0.last_of_run && push.res1.last_of_run))
		else $error("two results from one byte carry wrong last_of_run flags");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> codes.valid)
		else $error("byte input stalled while no result is waiting");

endmodule

`default_nettype wire
